>>> rtl/smq_alu_pkg.sv
// Shared constants and types for the sign-magnitude Q32.32 ALU.
package smq_alu_pkg;

  // Operand format: integer bits above fraction bits
  localparam int INT_BITS  = 32;
  localparam int FRAC_BITS = 32;
  localparam int MAG_W     = INT_BITS + FRAC_BITS;
  // Numerator and quotient register width for the fixed-point divide
  localparam int DQ_W      = MAG_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DQ_W);

  // Opcodes
  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_SUB  = 3'd1;
  localparam logic [2:0] ACT_MUL  = 3'd2;
  localparam logic [2:0] ACT_FDIV = 3'd3;
  localparam logic [2:0] ACT_IDIV = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB_AB,
    ST_SUB_BA,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> rtl/smq_alu_addsub.sv
// Shared add/subtract unit of the ALU sequencer.
module smq_alu_addsub (
  input  logic [smq_alu_pkg::MAG_W:0] x,
  input  logic [smq_alu_pkg::MAG_W:0] y,
  input  logic                        sub,
  output logic [smq_alu_pkg::MAG_W:0] sum,
  output logic                        carry
);
  import smq_alu_pkg::*;

  logic [MAG_W+1:0] full;

  // x + y, or x - y as x + ~y + 1; carry out means x >= y when subtracting
  assign full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (MAG_W+2)'(sub);
  assign sum   = full[MAG_W:0];
  assign carry = full[MAG_W+1];

endmodule

>>> rtl/sign_magnitude_q32_32_alu.sv
// Top level of the sign-magnitude Q32.32 fixed-point ALU.
//
// Input channel (in_*): opcode and two sign-magnitude operands. A transaction
// is taken when in_valid is high and in_stall is low. in_stall stays high
// from the cycle after an accepted transaction until its result has been
// moved into the output register.
// Output channel (out_*): one result per input transaction, held in an output
// register until the receiver takes it (out_valid high, out_stall low).
// A new input may be accepted while a finished result still waits there.
// All work runs through one 65-bit add/subtract unit under a sequencer:
//   add/subtract    : one add, or one or two subtract tries
//   multiply        : 64 shift-add steps
//   integer divide  : 64 restoring steps
//   fixed divide    : 96 restoring steps, numerator scaled 2^32
//   zero divisor or unknown opcode: straight to the result
// The next transaction can be taken in the same cycle in which out_valid rises.
// If the receiver stalls, the sequencer waits with a finished result until
// the output register frees up.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid.
module sign_magnitude_q32_32_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic        in_a_sign,
  input  logic [31:0] in_a_int,
  input  logic [31:0] in_a_frac,
  input  logic        in_b_sign,
  input  logic [31:0] in_b_int,
  input  logic [31:0] in_b_frac,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_r_sign,
  output logic [31:0] out_r_int,
  output logic [31:0] out_r_frac,
  output logic        out_overflow,
  output logic        out_div_zero
);
  import smq_alu_pkg::*;

  state_t             state_r, state_nxt;
  logic [2:0]         op_r, op_nxt;
  logic [MAG_W-1:0]   a_r, a_nxt;
  logic [MAG_W-1:0]   b_r, b_nxt;
  logic [MAG_W:0]     rem_r, rem_nxt;
  logic [DQ_W-1:0]    dq_r, dq_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               sa_r, sa_nxt;
  logic               sb_r, sb_nxt;
  logic               sign_r, sign_nxt;
  logic               dz_r, dz_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_sign_r, out_sign_nxt;
  logic [MAG_W-1:0]   out_mag_r, out_mag_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_dz_r, out_dz_nxt;

  logic [MAG_W-1:0]   ma, mb;
  logic               sb_eff;
  logic [MAG_W:0]     u_x, u_y, u_sum;
  logic               u_sub, u_carry;
  logic [MAG_W-1:0]   res_mag;
  logic               res_ovf;

  // Operand magnitudes, only the used bits of each part
  assign ma     = {in_a_int[INT_BITS-1:0], in_a_frac[FRAC_BITS-1:0]};
  assign mb     = {in_b_int[INT_BITS-1:0], in_b_frac[FRAC_BITS-1:0]};
  assign sb_eff = in_b_sign ^ (in_action == ACT_SUB);

  // Shared arithmetic unit
  smq_alu_addsub u_addsub (
    .x     (u_x),
    .y     (u_y),
    .sub   (u_sub),
    .sum   (u_sum),
    .carry (u_carry)
  );

  // Operand selection for the shared unit
  always_comb begin
    u_x   = {1'b0, a_r};
    u_y   = {1'b0, b_r};
    u_sub = 1'b0;
    case (state_r)
      ST_SUB_AB: begin
        u_sub = 1'b1;
      end
      ST_SUB_BA: begin
        u_x   = {1'b0, b_r};
        u_y   = {1'b0, a_r};
        u_sub = 1'b1;
      end
      ST_MUL: begin
        u_x = {1'b0, rem_r[MAG_W-1:0]};
        u_y = dq_r[0] ? {1'b0, b_r} : '0;
      end
      ST_DIV: begin
        u_x   = {rem_r[MAG_W-1:0], dq_r[DQ_W-1]};
        u_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result decode from the working registers
  always_comb begin
    res_mag = '0;
    res_ovf = 1'b0;
    if (!dz_r) begin
      case (op_r)
        ACT_ADD, ACT_SUB: begin
          res_mag = rem_r[MAG_W-1:0];
          res_ovf = rem_r[MAG_W];
        end
        ACT_MUL: begin
          res_mag = {rem_r[FRAC_BITS-1:0], dq_r[MAG_W-1:FRAC_BITS]};
          res_ovf = |rem_r[MAG_W-1:FRAC_BITS];
        end
        ACT_FDIV: begin
          res_mag = dq_r[MAG_W-1:0];
          res_ovf = |dq_r[DQ_W-1:MAG_W];
        end
        ACT_IDIV: begin
          res_mag = {dq_r[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
          res_ovf = |dq_r[MAG_W-1:INT_BITS];
        end
        default: begin
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    sa_r       <= sa_nxt;
    sb_r       <= sb_nxt;
    sign_r     <= sign_nxt;
    dz_r       <= dz_nxt;
    out_sign_r <= out_sign_nxt;
    out_mag_r  <= out_mag_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_dz_r   <= out_dz_nxt;
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    sign_nxt      = sign_r;
    dz_nxt        = dz_r;
    out_sign_nxt  = out_sign_r;
    out_mag_nxt   = out_mag_r;
    out_ovf_nxt   = out_ovf_r;
    out_dz_nxt    = out_dz_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_action;
          a_nxt    = ma;
          b_nxt    = mb;
          sa_nxt   = in_a_sign;
          sb_nxt   = sb_eff;
          sign_nxt = in_a_sign ^ in_b_sign;
          dz_nxt   = 1'b0;
          rem_nxt  = '0;
          case (in_action)
            ACT_ADD, ACT_SUB: begin
              state_nxt = (in_a_sign == sb_eff) ? ST_ADD : ST_SUB_AB;
            end
            ACT_MUL: begin
              dq_nxt    = {{FRAC_BITS{1'b0}}, ma};
              cnt_nxt   = CNT_W'(MAG_W - 1);
              state_nxt = ST_MUL;
            end
            ACT_FDIV, ACT_IDIV: begin
              dq_nxt  = {ma, {FRAC_BITS{1'b0}}};
              cnt_nxt = (in_action == ACT_FDIV) ? CNT_W'(DQ_W - 1) : CNT_W'(MAG_W - 1);
              if (mb == '0) begin
                // zero divisor: +0 with the flag
                dz_nxt    = 1'b1;
                sign_nxt  = 1'b0;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_DIV;
              end
            end
            default: begin
              sign_nxt  = 1'b0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // same effective signs: add magnitudes, carry is the overflow
      ST_ADD: begin
        rem_nxt   = u_sum;
        sign_nxt  = sa_r;
        state_nxt = ST_DONE;
      end

      // opposite signs: try a - b, fall back to b - a on borrow
      ST_SUB_AB: begin
        if (u_carry) begin
          rem_nxt   = u_sum;
          sign_nxt  = (u_sum[MAG_W-1:0] == '0) ? 1'b0 : sa_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SUB_BA;
        end
      end

      ST_SUB_BA: begin
        rem_nxt   = u_sum;
        sign_nxt  = sb_r;
        state_nxt = ST_DONE;
      end

      // shift-add multiply: high half in rem_r, low half in dq_r
      ST_MUL: begin
        rem_nxt             = {1'b0, u_sum[MAG_W:1]};
        dq_nxt[MAG_W-1:0]   = {u_sum[0], dq_r[MAG_W-1:1]};
        cnt_nxt             = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end

      // restoring divide: numerator bits leave the top of dq_r, quotient
      // bits enter at the bottom
      ST_DIV: begin
        rem_nxt = u_carry ? u_sum : u_x;
        dq_nxt  = {dq_r[DQ_W-2:0], u_carry};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sign_nxt  = sign_r;
          out_mag_nxt   = res_mag;
          out_ovf_nxt   = res_ovf;
          out_dz_nxt    = dz_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Ports
  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_r_sign   = out_sign_r;
  assign out_r_int    = 32'(out_mag_r[MAG_W-1:FRAC_BITS]);
  assign out_r_frac   = 32'(out_mag_r[FRAC_BITS-1:0]);
  assign out_overflow = out_ovf_r;
  assign out_div_zero = out_dz_r;

endmodule

>>> rtl/smq_alu_checker.sv
// Port-level assertions for the sign-magnitude ALU, bound to the top level.
module smq_alu_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_r_sign,
  input logic [31:0] out_r_int,
  input logic [31:0] out_r_frac,
  input logic        out_overflow,
  input logic        out_div_zero
);

  // An accepted transaction keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted transaction");

  // A divide-by-zero result is always +0 without overflow
  a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |->
      out_r_int == 32'd0 && out_r_frac == 32'd0 && !out_r_sign && !out_overflow)
    else $error("divide-by-zero result is not +0");

  // A stalled result stays valid
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_r_int) && $stable(out_r_frac) && $stable(out_r_sign) &&
      $stable(out_overflow) && $stable(out_div_zero))
    else $error("result changed while stalled");

endmodule

bind sign_magnitude_q32_32_alu smq_alu_sva u_smq_alu_checker (.*);
